[rtl/core/kalman_position_rate_filter_defines.svh]
// assertion macros shared by the filter rtl
`ifndef KALMAN_POSITION_RATE_FILTER_DEFINES_SVH
`define KALMAN_POSITION_RATE_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define KPRF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kprf: assertion failed");
// clocked check, also live during reset
`define KPRF_ASSERT_NR(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("kprf: assertion failed");
`else
`define KPRF_ASSERT(label, prop)
`define KPRF_ASSERT_NR(label, prop)
`endif
`endif

[rtl/core/kprf_pkg.sv]
`default_nettype none
package kprf_pkg;

    // default arithmetic format
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // configuration port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int DT_W       = 16;

    // register reset values
    localparam logic [DT_W-1:0]       DT_RST    = 16'd3277;
    localparam logic [CFG_DATA_W-1:0] QPOS_RST  = 21'd6554;
    localparam logic [CFG_DATA_W-1:0] QRATE_RST = 21'd655;
    localparam logic [CFG_DATA_W-1:0] RMEAS_RST = 21'd1311;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP,
        CFG_QPOS,
        CFG_QRATE,
        CFG_RMEAS
    } cfg_index_t;

endpackage
`default_nettype wire

[rtl/core/kprf_mul.sv]
`default_nettype none
module kprf_mul #(
    parameter int DATA_WIDTH = kprf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kprf_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [DATA_WIDTH-1:0] b,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] product
);
    import kprf_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam int RW = 2 * W + 1;

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

    mstate_t             state_reg;
    logic [W-1:0]        mcand_reg;
    logic [W-1:0]        mplier_reg;
    logic [2*W-1:0]      acc_reg;
    logic                neg_reg;
    logic [CW-1:0]       cnt_reg;
    logic signed [W-1:0] res_reg;
    logic                done_reg;

    logic [W-1:0]        mag_a;
    logic [W-1:0]        mag_b;
    logic [W:0]          add_sum;
    logic [RW-1:0]       rnd;
    logic [RW-1:0]       mg;
    logic [RW-1:0]       cap;
    logic signed [W-1:0] fin_val;

    // operand magnitudes
    assign mag_a = a[W-1] ? W'(-a) : W'(a);
    assign mag_b = b[W-1] ? W'(-b) : W'(b);

    // one multiplier bit per cycle into the upper half
    assign add_sum = {1'b0, acc_reg[2*W-1:W]}
                   + (mplier_reg[0] ? {1'b0, mcand_reg} : {(W+1){1'b0}});

    // round to nearest, drop fraction bits, saturate
    assign rnd = {1'b0, acc_reg} + (RW'(1) << (FRAC_BITS - 1));
    assign mg  = rnd >> FRAC_BITS;
    assign cap = RW'(1) << (W - 1);

    always_comb
    begin
        if (neg_reg)
        begin
            if (mg > cap)
                fin_val = {1'b1, {(W-1){1'b0}}};
            else
                fin_val = -$signed(mg[W-1:0]);
        end
        else
        begin
            if (mg >= cap)
                fin_val = {1'b0, {(W-1){1'b1}}};
            else
                fin_val = $signed(mg[W-1:0]);
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= M_IDLE;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            cnt_reg    <= '0;
            res_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        mcand_reg  <= mag_a;
                        mplier_reg <= mag_b;
                        acc_reg    <= '0;
                        neg_reg    <= a[W-1] ^ b[W-1];
                        cnt_reg    <= CW'(W);
                        state_reg  <= M_RUN;
                    end
                end
                M_RUN:
                begin
                    acc_reg    <= {add_sum, acc_reg[W-1:1]};
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                        state_reg <= M_FIN;
                end
                M_FIN:
                begin
                    res_reg   <= fin_val;
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign product = res_reg;

endmodule
`default_nettype wire

[rtl/core/kprf_div.sv]
`default_nettype none
module kprf_div #(
    parameter int DATA_WIDTH = kprf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kprf_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] num,
    input  logic signed [DATA_WIDTH-1:0] den,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] quot
);
    import kprf_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int QW = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

    dstate_t             state_reg;
    logic [QW-1:0]       dvd_reg;
    logic [QW-1:0]       q_reg;
    logic [W-1:0]        rem_reg;
    logic [W-1:0]        den_reg;
    logic                neg_reg;
    logic [CW-1:0]       cnt_reg;
    logic signed [W-1:0] res_reg;
    logic                done_reg;

    logic [W-1:0]        mag_n;
    logic [W-1:0]        trial;
    logic                ge;
    logic [QW-1:0]       cap;
    logic signed [W-1:0] fin_val;

    assign mag_n = num[W-1] ? W'(-num) : W'(num);

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg[W-2:0], dvd_reg[QW-1]};
    assign ge    = (trial >= den_reg);

    // saturate the quotient magnitude with its sign
    assign cap = QW'(1) << (W - 1);

    always_comb
    begin
        if (q_reg > cap)
            fin_val = neg_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else if (neg_reg)
            fin_val = -$signed(q_reg[W-1:0]);
        else if (q_reg == cap)
            fin_val = {1'b0, {(W-1){1'b1}}};
        else
            fin_val = $signed(q_reg[W-1:0]);
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            dvd_reg   <= '0;
            q_reg     <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            res_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        dvd_reg   <= {mag_n, {FRAC_BITS{1'b0}}};
                        q_reg     <= '0;
                        rem_reg   <= '0;
                        den_reg   <= den;
                        neg_reg   <= num[W-1];
                        cnt_reg   <= CW'(QW);
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg   <= ge ? (trial - den_reg) : trial;
                    q_reg     <= {q_reg[QW-2:0], ge};
                    dvd_reg   <= dvd_reg << 1;
                    cnt_reg   <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                        state_reg <= D_FIN;
                end
                D_FIN:
                begin
                    res_reg   <= fin_val;
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quot = res_reg;

endmodule
`default_nettype wire

[rtl/core/kalman_position_rate_filter.sv]
`default_nettype none
`include "kalman_position_rate_filter_defines.svh"
// Two-state (position, rate) Kalman filter on signed fixed point with FRAC_BITS fraction
// bits held at DATA_WIDTH bits; one measurement word in gives one word out carrying the
// corrected position and rate, saturated to 32 bits. State resets to zero with identity
// covariance. Nine multiplies go one at a time through a shift-add unit that retires one
// multiplier bit a cycle, and the two gains through a restoring divider that retires one
// quotient bit a cycle. One word is worked at a time; in_stall is high while it is in
// flight. The next word may be taken while the previous result still waits on the output.
// Configuration registers are written through the cfg channel, which is always ready; the user
// must write them only while the block is idle, as the block itself does not enforce this.
module kalman_position_rate_filter #(
    parameter int DATA_WIDTH = kprf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kprf_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [31:0]                  measurement,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [31:0]                  position_estimate,
    output logic signed [31:0]                  rate_estimate,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kprf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kprf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import kprf_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int XW = DATA_WIDTH + 34;

    typedef enum logic [3:0] {
        ST_IDLE, ST_XP, ST_M01, ST_M00A, ST_M00B, ST_S, ST_K0, ST_K1,
        ST_EP, ST_ER, ST_P00, ST_P01, ST_P11, ST_DONE
    } state_t;

    // saturate a widened value to the data range
    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[W-1:0];
        else if (v < lo)
            return lo[W-1:0];
        else
            return v[W-1:0];
    endfunction

    // saturate a widened value to the 32 bit output range
    function automatic logic signed [31:0] sat_32(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = {{(XW-31){1'b0}}, {31{1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[31:0];
        else if (v < lo)
            return lo[31:0];
        else
            return v[31:0];
    endfunction

    function automatic logic signed [XW-1:0] ext(input logic signed [W-1:0] v);
        return XW'(v);
    endfunction

    state_t                  state_reg;
    logic                    issued_reg;
    logic                    out_valid_reg;
    logic signed [31:0]      pos_out_reg;
    logic signed [31:0]      rate_out_reg;

    logic [DT_W-1:0]         dt_reg;
    logic [CFG_DATA_W-1:0]   qpos_reg;
    logic [CFG_DATA_W-1:0]   qrate_reg;
    logic [CFG_DATA_W-1:0]   rmeas_reg;

    logic signed [W-1:0]     est_pos_reg;
    logic signed [W-1:0]     est_rate_reg;
    logic signed [W-1:0]     p00_reg;
    logic signed [W-1:0]     p01_reg;
    logic signed [W-1:0]     p11_reg;
    logic signed [W-1:0]     z_reg;
    logic signed [W-1:0]     xp_reg;
    logic signed [W-1:0]     m00_reg;
    logic signed [W-1:0]     m01_reg;
    logic signed [W-1:0]     m11_reg;
    logic signed [W-1:0]     s_reg;
    logic signed [W-1:0]     y_reg;
    logic signed [W-1:0]     k0_reg;
    logic signed [W-1:0]     k1_reg;

    logic signed [W-1:0]     dt_w;
    logic signed [W-1:0]     s_sum;
    logic                    mul_op;
    logic                    div_op;
    logic                    mul_start;
    logic                    div_start;
    logic signed [W-1:0]     mul_a;
    logic signed [W-1:0]     mul_b;
    logic signed [W-1:0]     div_n;
    logic                    mul_done;
    logic                    div_done;
    logic signed [W-1:0]     mul_res;
    logic signed [W-1:0]     div_res;

    assign dt_w  = $signed(W'(dt_reg));
    assign s_sum = sat_w(ext(m00_reg) + XW'(rmeas_reg));

    // operand selection for the shared units
    always_comb
    begin
        mul_op = 1'b1;
        div_op = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        div_n  = m00_reg;
        case (state_reg)
            ST_XP:   begin mul_a = dt_w;   mul_b = est_rate_reg; end
            ST_M01:  begin mul_a = dt_w;   mul_b = p11_reg;      end
            ST_M00A: begin mul_a = dt_w;   mul_b = p01_reg;      end
            ST_M00B: begin mul_a = dt_w;   mul_b = m01_reg;      end
            ST_EP:   begin mul_a = k0_reg; mul_b = y_reg;        end
            ST_ER:   begin mul_a = k1_reg; mul_b = y_reg;        end
            ST_P00:  begin mul_a = k0_reg; mul_b = m00_reg;      end
            ST_P01:  begin mul_a = k0_reg; mul_b = m01_reg;      end
            ST_P11:  begin mul_a = k1_reg; mul_b = m01_reg;      end
            ST_K0:   begin mul_op = 1'b0; div_op = 1'b1; div_n = m00_reg; end
            ST_K1:   begin mul_op = 1'b0; div_op = 1'b1; div_n = m01_reg; end
            default: begin mul_op = 1'b0; end
        endcase
    end

    assign mul_start = mul_op && !issued_reg;
    assign div_start = div_op && !issued_reg;

    kprf_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_res)
    );

    kprf_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_n),
        .den   (s_reg),
        .done  (div_done),
        .quot  (div_res)
    );

    // sequencer, filter state and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_out_reg   <= '0;
            rate_out_reg  <= '0;
            dt_reg        <= DT_RST;
            qpos_reg      <= QPOS_RST;
            qrate_reg     <= QRATE_RST;
            rmeas_reg     <= RMEAS_RST;
            est_pos_reg   <= '0;
            est_rate_reg  <= '0;
            p00_reg       <= sat_w(XW'(1) << FRAC_BITS);
            p01_reg       <= '0;
            p11_reg       <= sat_w(XW'(1) << FRAC_BITS);
            z_reg         <= '0;
            xp_reg        <= '0;
            m00_reg       <= '0;
            m01_reg       <= '0;
            m11_reg       <= '0;
            s_reg         <= '0;
            y_reg         <= '0;
            k0_reg        <= '0;
            k1_reg        <= '0;
        end
        else
        begin
            // register writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_TIME_STEP: dt_reg    <= cfg_data[DT_W-1:0];
                    CFG_QPOS:      qpos_reg  <= cfg_data;
                    CFG_QRATE:     qrate_reg <= cfg_data;
                    CFG_RMEAS:     rmeas_reg <= cfg_data;
                    default:       ;
                endcase
            end

            // output word taken, unless a new one replaces it below
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
                out_valid_reg <= 1'b0;

            if (mul_start || div_start)
                issued_reg <= 1'b1;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        z_reg     <= sat_w(XW'(measurement));
                        state_reg <= ST_XP;
                    end
                end
                ST_XP:
                begin
                    if (mul_done)
                    begin
                        xp_reg     <= sat_w(ext(est_pos_reg) + ext(mul_res));
                        issued_reg <= 1'b0;
                        state_reg  <= ST_M01;
                    end
                end
                ST_M01:
                begin
                    if (mul_done)
                    begin
                        m01_reg    <= sat_w(ext(p01_reg) + ext(mul_res));
                        issued_reg <= 1'b0;
                        state_reg  <= ST_M00A;
                    end
                end
                ST_M00A:
                begin
                    if (mul_done)
                    begin
                        m00_reg    <= sat_w(ext(p00_reg) + ext(mul_res));
                        issued_reg <= 1'b0;
                        state_reg  <= ST_M00B;
                    end
                end
                ST_M00B:
                begin
                    if (mul_done)
                    begin
                        m00_reg    <= sat_w(ext(sat_w(ext(m00_reg) + ext(mul_res)))
                                            + XW'(qpos_reg));
                        issued_reg <= 1'b0;
                        state_reg  <= ST_S;
                    end
                end
                ST_S:
                begin
                    // innovation variance, kept at least one lsb
                    s_reg     <= (s_sum < 1) ? W'(1) : s_sum;
                    m11_reg   <= sat_w(ext(p11_reg) + XW'(qrate_reg));
                    y_reg     <= sat_w(ext(z_reg) - ext(xp_reg));
                    state_reg <= ST_K0;
                end
                ST_K0:
                begin
                    if (div_done)
                    begin
                        k0_reg     <= div_res;
                        issued_reg <= 1'b0;
                        state_reg  <= ST_K1;
                    end
                end
                ST_K1:
                begin
                    if (div_done)
                    begin
                        k1_reg     <= div_res;
                        issued_reg <= 1'b0;
                        state_reg  <= ST_EP;
                    end
                end
                ST_EP:
                begin
                    if (mul_done)
                    begin
                        est_pos_reg <= sat_w(ext(xp_reg) + ext(mul_res));
                        issued_reg  <= 1'b0;
                        state_reg   <= ST_ER;
                    end
                end
                ST_ER:
                begin
                    if (mul_done)
                    begin
                        est_rate_reg <= sat_w(ext(est_rate_reg) + ext(mul_res));
                        issued_reg   <= 1'b0;
                        state_reg    <= ST_P00;
                    end
                end
                ST_P00:
                begin
                    if (mul_done)
                    begin
                        p00_reg    <= sat_w(ext(m00_reg) - ext(mul_res));
                        issued_reg <= 1'b0;
                        state_reg  <= ST_P01;
                    end
                end
                ST_P01:
                begin
                    if (mul_done)
                    begin
                        p01_reg    <= sat_w(ext(m01_reg) - ext(mul_res));
                        issued_reg <= 1'b0;
                        state_reg  <= ST_P11;
                    end
                end
                ST_P11:
                begin
                    if (mul_done)
                    begin
                        p11_reg    <= sat_w(ext(m11_reg) - ext(mul_res));
                        issued_reg <= 1'b0;
                        state_reg  <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    // hand over the word once the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        pos_out_reg   <= sat_32(ext(est_pos_reg));
                        rate_out_reg  <= sat_32(ext(est_rate_reg));
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall          = (state_reg != ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign position_estimate = pos_out_reg;
    assign rate_estimate     = rate_out_reg;
    assign cfg_ready         = 1'b1;

    // checks
    `KPRF_ASSERT(a_out_from_done, $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
    `KPRF_ASSERT(a_div_positive, div_start |-> (s_reg > 0))
    `KPRF_ASSERT(a_result_issued, (mul_done || div_done) |-> issued_reg)
    `KPRF_ASSERT_NR(a_idle_clear, (state_reg == ST_IDLE) |-> !issued_reg)

endmodule
`default_nettype wire
